@@ rtl/core/hars_pkg.sv @@
// Shared types and constants for the health-aware round-robin selector.
`timescale 1ns / 1ps
package hars_pkg;

  localparam int MaxServersDef = 16;
  localparam int CntW          = 14;
  localparam int SrvCntW       = 5;
  localparam int IdxW          = 4;
  localparam int TickW         = 32;
  localparam int LimW          = 16;

  localparam logic [CntW-1:0] CntLimit = CntW'(10000);

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_SET    = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    H_NORMAL  = 2'd0,
    H_DEAD    = 2'd1,
    H_REBOOT  = 2'd2,
    H_TESTING = 2'd3
  } health_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    health_t          health;
    logic [TickW-1:0] since;
    logic [LimW-1:0]  limit;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

@@ rtl/core/hars_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hars_mod.sv @@
// Iterative restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module hars_mod import hars_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CntW-1:0]    dividend,
  input  logic [SrvCntW-1:0] divisor,
  output logic               done,
  output logic [SrvCntW-1:0] remainder
);

  localparam int StepW = $clog2(CntW + 1);

  logic               busy;
  logic [StepW-1:0]   steps;
  logic [CntW-1:0]    dvd;
  logic [SrvCntW-1:0] dsr;
  logic [SrvCntW:0]   trial;
  logic [SrvCntW-1:0] rem_next;

  // shared compare/subtract: bring down one bit, subtract if it fits
  always_comb begin
    trial = {remainder, dvd[CntW-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = SrvCntW'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[SrvCntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepW'(CntW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= {dvd[CntW-2:0], 1'b0};
      remainder <= rem_next;
    end
  end

endmodule

@@ rtl/core/health_aware_round_robin_selector.sv @@
// Top level: health-aware round-robin server selector with sequencer.
`timescale 1ns / 1ps
// Select beat, from accept to result: 14 remainder steps, a hand-off, k table reads with
//   the last one judged after its read, then an output load; k = probes, 1..clamped server count.
//   A stalled result holds the output load until the prior result is taken.
// Set-state and tick beats are applied when accepted. One beat in flight.
// Reset (rst, synchronous): server_count = 1, counter and clock zero, all servers normal
//   via per-entry valid bits; the table RAM itself is not swept.
module health_aware_round_robin_selector import hars_pkg::*; #(
  parameter int MAX_SERVERS = MaxServersDef
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wen,
  input  logic [SrvCntW-1:0] cfg_wdata,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [IdxW-1:0]    server_index,
  input  logic [1:0]         new_state,
  input  logic [LimW-1:0]    timeout_ticks,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IdxW-1:0]    chosen_server,
  output logic               found,
  output logic               revived
);

  // table address width
  localparam int AW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  // common width for comparing addresses against counts
  localparam int CmpW = ((AW > SrvCntW) ? AW : SrvCntW) + 1;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_SERVERS);

  // ---------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------
  state_t             state, state_next;
  logic [SrvCntW-1:0] server_count;
  logic [CntW-1:0]    request_counter, request_counter_next;
  logic [TickW-1:0]   now_ticks, now_ticks_next;
  logic [MAX_SERVERS-1:0] vld, vld_next;

  // select scratch
  logic [SrvCntW-1:0] n_act, n_act_next;      // active server count of this select
  logic [AW-1:0]      start_idx, start_idx_next;
  logic [AW-1:0]      ptr, ptr_next;          // next address to read
  logic [AW-1:0]      eval_ptr, eval_ptr_next; // address whose data is in rdata
  logic               pend, pend_next;        // rdata holds a fresh entry
  logic [SrvCntW-1:0] iss_cnt, iss_cnt_next;
  logic [SrvCntW-1:0] eval_cnt, eval_cnt_next;
  logic               vld_q;

  // result holding
  logic [AW-1:0]      res_chosen, res_chosen_next;
  logic               res_found, res_found_next;
  logic               res_revived, res_revived_next;
  logic               out_valid_next;
  logic [IdxW-1:0]    chosen_server_next;
  logic               found_next, revived_next;

  // table RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  // remainder unit
  logic               mod_start;
  logic               mod_done;
  logic [SrvCntW-1:0] mod_rem;

  // ---------------------------------------------------------------------
  // Derived control
  // ---------------------------------------------------------------------
  logic               in_acc;
  logic               out_acc;
  logic [SrvCntW-1:0] n_cfg;         // server_count clamped to 1..MAX_SERVERS
  entry_t             cur;           // entry under evaluation, reset value if never written
  logic [TickW-1:0]   elapsed;
  logic               expired;
  logic               qual_norm, qual_rev;
  logic               set_ok;
  logic [AW-1:0]      ptr_inc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    if (server_count == '0) begin
      n_cfg = SrvCntW'(1);
    end else if ({{(CmpW-SrvCntW){1'b0}}, server_count} > MaxCmp) begin
      n_cfg = SrvCntW'(MAX_SERVERS);
    end else begin
      n_cfg = server_count;
    end
  end

  // indexes at or beyond the table depth are dropped
  assign set_ok = ({{(CmpW-IdxW){1'b0}}, server_index} < MaxCmp);

  // circular step within the active set
  always_comb begin
    if ({{(CmpW-AW){1'b0}}, ptr} + CmpW'(1) == {{(CmpW-SrvCntW){1'b0}}, n_act}) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = ptr + 1'b1;
    end
  end

  // entry decode and expiry test
  always_comb begin
    if (vld_q) begin
      cur = ram_rdata;
    end else begin
      cur.health = H_NORMAL;
      cur.since  = '0;
      cur.limit  = '0;
    end
    elapsed   = now_ticks - cur.since;
    expired   = elapsed > {{(TickW-LimW){1'b0}}, cur.limit};
    qual_norm = (cur.health == H_NORMAL);
    qual_rev  = ((cur.health == H_DEAD) || (cur.health == H_REBOOT)) && expired;
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // ---------------------------------------------------------------------
  always_comb begin
    state_next           = state;
    request_counter_next = request_counter;
    now_ticks_next       = now_ticks;
    vld_next             = vld;
    n_act_next           = n_act;
    start_idx_next       = start_idx;
    ptr_next             = ptr;
    eval_ptr_next        = eval_ptr;
    pend_next            = 1'b0;
    iss_cnt_next         = iss_cnt;
    eval_cnt_next        = eval_cnt;
    res_chosen_next      = res_chosen;
    res_found_next       = res_found;
    res_revived_next     = res_revived;
    out_valid_next       = out_valid && !out_acc;
    chosen_server_next   = chosen_server;
    found_next           = found;
    revived_next         = revived;
    in_stall             = (state != ST_IDLE);
    mod_start            = 1'b0;
    ram_we               = 1'b0;
    ram_waddr            = AW'(server_index);
    ram_wdata.health     = health_t'(new_state);
    ram_wdata.since      = now_ticks;
    ram_wdata.limit      = timeout_ticks;
    ram_raddr            = ptr;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (op == OP_SELECT) begin
            mod_start  = 1'b1;
            n_act_next = n_cfg;
            if (request_counter > CntLimit) begin
              request_counter_next = '0;
            end else begin
              request_counter_next = request_counter + 1'b1;
            end
            state_next = ST_MOD;
          end else if (op == OP_SET) begin
            if (set_ok) begin
              ram_we              = 1'b1;
              vld_next[ram_waddr] = 1'b1;
            end
          end else if (op == OP_TICK) begin
            now_ticks_next = now_ticks + 1'b1;
          end
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          start_idx_next = AW'(mod_rem);
          ptr_next       = AW'(mod_rem);
          iss_cnt_next   = '0;
          eval_cnt_next  = '0;
          state_next     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle while probes remain
        if (iss_cnt != n_act) begin
          ram_raddr     = ptr;
          pend_next     = 1'b1;
          eval_ptr_next = ptr;
          ptr_next      = ptr_inc;
          iss_cnt_next  = iss_cnt + 1'b1;
        end
        // evaluate the entry read last cycle
        if (pend) begin
          eval_cnt_next = eval_cnt + 1'b1;
          if (qual_norm || qual_rev) begin
            res_chosen_next  = eval_ptr;
            res_found_next   = 1'b1;
            res_revived_next = qual_rev;
            state_next       = ST_DONE;
            if (qual_rev) begin
              // revive: move to testing, clear the timestamp, keep the limit
              ram_we           = 1'b1;
              ram_waddr        = eval_ptr;
              ram_wdata.health = H_TESTING;
              ram_wdata.since  = '0;
              ram_wdata.limit  = cur.limit;
            end
          end else if (eval_cnt + 1'b1 == n_act) begin
            res_chosen_next  = start_idx;
            res_found_next   = 1'b0;
            res_revived_next = 1'b0;
            state_next       = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || out_acc) begin
          out_valid_next     = 1'b1;
          chosen_server_next = IdxW'(res_chosen);
          found_next         = res_found;
          revived_next       = res_revived;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      server_count    <= SrvCntW'(1);
      request_counter <= '0;
      now_ticks       <= '0;
      vld             <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      if (cfg_wen) begin
        server_count <= cfg_wdata;
      end
      request_counter <= request_counter_next;
      now_ticks       <= now_ticks_next;
      vld             <= vld_next;
      pend            <= pend_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_act         <= n_act_next;
    start_idx     <= start_idx_next;
    ptr           <= ptr_next;
    eval_ptr      <= eval_ptr_next;
    iss_cnt       <= iss_cnt_next;
    eval_cnt      <= eval_cnt_next;
    res_chosen    <= res_chosen_next;
    res_found     <= res_found_next;
    res_revived   <= res_revived_next;
    chosen_server <= chosen_server_next;
    found         <= found_next;
    revived       <= revived_next;
    vld_q         <= vld[ram_raddr];
  end

  // ---------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------
  hars_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (request_counter),
    .divisor   (n_cfg),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  hars_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_SERVERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_revive_needs_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found || !revived))
    else $error("revived flagged without a found server");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    request_counter <= CntLimit + 1'b1)
    else $error("request counter beyond wrap point");

  a_scan_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({{(CmpW-AW){1'b0}}, ptr} < {{(CmpW-SrvCntW){1'b0}}, n_act}))
    else $error("scan pointer outside active set");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MOD))
    else $error("remainder unit finished outside its phase");

endmodule
